>>> rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types, command codes and the control store of the cursor sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

    // Command codes of the input word
    typedef enum logic [3:0] {
        CMD_LF      = 4'd0,
        CMD_BS      = 4'd1,
        CMD_CR      = 4'd2,
        CMD_NEXTLN  = 4'd3,
        CMD_PREVLN  = 4'd4,
        CMD_BACKCH  = 4'd5,
        CMD_FWDCH   = 4'd6,
        CMD_TAB     = 4'd7,
        CMD_SETL    = 4'd8,
        CMD_SETR    = 4'd9,
        CMD_CLRM    = 4'd10
    } cmd_t;

    // Configuration register indexes
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    // Register reset values (last row / last column)
    localparam logic [7:0] LAST_ROW_RST = 8'd23;
    localparam logic [7:0] LAST_COL_RST = 8'd79;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        UOP_NOP    = 4'd0,
        UOP_LF     = 4'd1,
        UOP_BS     = 4'd2,
        UOP_CR     = 4'd3,
        UOP_ROWDN  = 4'd4,
        UOP_ROWUP  = 4'd5,
        UOP_COLBK  = 4'd6,
        UOP_COLFW  = 4'd7,
        UOP_TAB    = 4'd8,
        UOP_SETL   = 4'd9,
        UOP_SETR   = 4'd10,
        UOP_CLRM   = 4'd11
    } uop_t;

    typedef logic [3:0] uaddr_t;

    // Control store addresses
    localparam uaddr_t UA_LF     = 4'd0;
    localparam uaddr_t UA_BS     = 4'd1;
    localparam uaddr_t UA_CR     = 4'd2;
    localparam uaddr_t UA_NEXTLN = 4'd3;
    localparam uaddr_t UA_PREVLN = 4'd4;
    localparam uaddr_t UA_BACKCH = 4'd5;
    localparam uaddr_t UA_FWDCH  = 4'd6;
    localparam uaddr_t UA_TAB    = 4'd7;
    localparam uaddr_t UA_SETL   = 4'd8;
    localparam uaddr_t UA_SETR   = 4'd9;
    localparam uaddr_t UA_CLRM   = 4'd10;
    localparam uaddr_t UA_FIN    = 4'd11;

    // One control word: loop words repeat while the count is nonzero,
    // then jump to target; done words retire the command.
    typedef struct packed {
        uop_t   op;
        logic   loop;
        logic   done;
        uaddr_t target;
    } uword_t;

    // Sequencer to datapath control
    typedef struct packed {
        logic en;
        uop_t op;
    } ctl_t;

    // Datapath result (values after the current step)
    typedef struct packed {
        logic       bell;
        logic       scroll;
        logic [7:0] column;
        logic [7:0] row;
    } res_t;

    // Control store
    function automatic uword_t ucode(input uaddr_t addr);
        uword_t w;
        unique case (addr)
            UA_LF:     w = '{op: UOP_LF,    loop: 1'b0, done: 1'b1, target: UA_FIN};
            UA_BS:     w = '{op: UOP_BS,    loop: 1'b0, done: 1'b1, target: UA_FIN};
            UA_CR:     w = '{op: UOP_CR,    loop: 1'b0, done: 1'b1, target: UA_FIN};
            UA_NEXTLN: w = '{op: UOP_ROWDN, loop: 1'b1, done: 1'b0, target: UA_FIN};
            UA_PREVLN: w = '{op: UOP_ROWUP, loop: 1'b1, done: 1'b0, target: UA_FIN};
            UA_BACKCH: w = '{op: UOP_COLBK, loop: 1'b1, done: 1'b0, target: UA_FIN};
            UA_FWDCH:  w = '{op: UOP_COLFW, loop: 1'b1, done: 1'b0, target: UA_FIN};
            UA_TAB:    w = '{op: UOP_TAB,   loop: 1'b0, done: 1'b1, target: UA_FIN};
            UA_SETL:   w = '{op: UOP_SETL,  loop: 1'b0, done: 1'b1, target: UA_FIN};
            UA_SETR:   w = '{op: UOP_SETR,  loop: 1'b0, done: 1'b1, target: UA_FIN};
            UA_CLRM:   w = '{op: UOP_CLRM,  loop: 1'b0, done: 1'b1, target: UA_FIN};
            default:   w = '{op: UOP_NOP,   loop: 1'b0, done: 1'b1, target: UA_FIN};
        endcase
        return w;
    endfunction

    // Dispatch: command code to entry address; unused codes retire at once
    function automatic uaddr_t entry(input logic [3:0] cmd);
        uaddr_t a;
        if (cmd <= CMD_CLRM) begin
            a = cmd;
        end else begin
            a = UA_FIN;
        end
        return a;
    endfunction

endpackage

`default_nettype wire

>>> rtl/terminal_cursor_controller.sv
// ----------------------------------------------------------------------------
// terminal_cursor_controller
// Text terminal cursor tracker driven by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one command word (cmd, count); the master stream
//   returns one result word (row, column, scroll, bell) per command.
//   The configuration port writes num_rows (index 0) or num_cols (index 1);
//   write only while no command is in flight.
//   Each command is dispatched to an entry of the control store. Single
//   commands take one sequencer step; next/previous line and back/forward
//   character repeat one step per cycle while count remains, then retire.
//   The result word is valid the cycle after the last step, and the next
//   command can be taken in that same cycle. One command is in flight at a
//   time. If the receiver stalls, the last step of the following command
//   waits until the held word is taken.
//   Reset (synchronous, active low) homes the cursor, sets margins 0..79,
//   a 24 x 80 screen and drops m_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_cursor_controller (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // command stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [3:0] cmd, [11:4] count, rest zero
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] row, [15:8] column,
                                        // [16] scroll, [17] bell, rest zero
    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [8:0]  cfg_wdata
);

    logic            busy_reg, busy_next;
    tcc_pkg::uaddr_t pc_reg, pc_next;
    logic [7:0]      cnt_reg, cnt_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [23:0]     m_tdata_reg;
    tcc_pkg::uword_t uw;
    tcc_pkg::ctl_t   ctl;
    tcc_pkg::res_t   res;
    logic            s_fire;
    logic            out_free;
    logic            retire;

    assign s_tready = !busy_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Control store read
    assign uw = tcc_pkg::ucode(pc_reg);

    // Step enable: loop words while count remains, done words once the
    // output register is free
    assign retire = busy_reg && !uw.loop && uw.done && out_free;
    always_comb begin
        ctl.op = uw.op;
        if (uw.loop) begin
            ctl.en = busy_reg && (cnt_reg != 8'd0);
        end else begin
            ctl.en = busy_reg && (!uw.done || out_free);
        end
    end

    // Sequencer
    always_comb begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        cnt_next  = cnt_reg;
        if (s_fire) begin
            busy_next = 1'b1;
            pc_next   = tcc_pkg::entry(s_tdata[3:0]);
            cnt_next  = s_tdata[11:4];
        end else if (busy_reg) begin
            if (uw.loop) begin
                if (cnt_reg == 8'd0) begin
                    pc_next = uw.target;
                end else begin
                    cnt_next = cnt_reg - 8'd1;
                end
            end else if (uw.done) begin
                if (out_free) busy_next = 1'b0;
            end else begin
                pc_next = pc_reg + tcc_pkg::uaddr_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pc_reg   <= tcc_pkg::UA_FIN;
            cnt_reg  <= 8'd0;
        end else begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            cnt_reg  <= cnt_next;
        end
    end

    tcc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .res       (res)
    );

    // Output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (retire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (retire) begin
            m_tdata_reg <= {6'd0, res.bell, res.scroll, res.column, res.row};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> rtl/tcc_datapath.sv
// ----------------------------------------------------------------------------
// tcc_datapath
// Cursor, margin and screen size registers with the step logic for each
// micro-operation.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_datapath (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire tcc_pkg::ctl_t ctl,
    input  wire logic          cfg_we,
    input  wire logic          cfg_addr,
    input  wire logic [8:0]    cfg_wdata,
    output tcc_pkg::res_t      res
);

    logic [7:0] row_reg, row_next;
    logic [7:0] col_reg, col_next;
    logic [7:0] ml_reg,  ml_next;
    logic [7:0] mr_reg,  mr_next;
    logic [7:0] last_row_reg;
    logic [7:0] last_col_reg;
    logic [7:0] cfg_last;
    logic       scroll;
    logic       bell;
    logic [8:0] row_inc;
    logic [8:0] tab_stop;

    // Screen size as a last index: 0 acts as 1, above 256 acts as 256
    always_comb begin
        priority if (cfg_wdata == 9'd0) begin
            cfg_last = 8'd0;
        end else if (cfg_wdata[8]) begin
            cfg_last = 8'd255;
        end else begin
            cfg_last = cfg_wdata[7:0] - 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_row_reg <= tcc_pkg::LAST_ROW_RST;
            last_col_reg <= tcc_pkg::LAST_COL_RST;
        end else if (cfg_we) begin
            if (cfg_addr == tcc_pkg::REG_NUM_ROWS) begin
                last_row_reg <= cfg_last;
            end else begin
                last_col_reg <= cfg_last;
            end
        end
    end

    assign row_inc  = {1'b0, row_reg} + 9'd1;
    assign tab_stop = {({1'b0, col_reg[7:3]} + 6'd1), 3'b000};

    // Step logic
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        ml_next  = ml_reg;
        mr_next  = mr_reg;
        scroll   = 1'b0;
        bell     = 1'b0;
        unique case (ctl.op)
            tcc_pkg::UOP_LF: begin
                if (row_inc > {1'b0, last_row_reg}) begin
                    row_next = last_row_reg;
                    scroll   = 1'b1;
                end else begin
                    row_next = row_inc[7:0];
                end
            end
            tcc_pkg::UOP_BS: begin
                if (col_reg != 8'd0) col_next = col_reg - 8'd1;
            end
            tcc_pkg::UOP_CR: begin
                col_next = ml_reg;
            end
            tcc_pkg::UOP_ROWDN: begin
                row_next = (row_reg < last_row_reg) ? row_inc[7:0] : 8'd0;
            end
            tcc_pkg::UOP_ROWUP: begin
                row_next = (row_reg != 8'd0) ? row_reg - 8'd1 : last_row_reg;
            end
            tcc_pkg::UOP_COLBK: begin
                if (col_reg != 8'd0) begin
                    col_next = col_reg - 8'd1;
                end else begin
                    col_next = last_col_reg;
                    row_next = (row_reg != 8'd0) ? row_reg - 8'd1 : last_row_reg;
                end
            end
            tcc_pkg::UOP_COLFW: begin
                if (col_reg < last_col_reg) begin
                    col_next = col_reg + 8'd1;
                end else begin
                    col_next = 8'd0;
                    row_next = (row_reg < last_row_reg) ? row_inc[7:0] : 8'd0;
                end
            end
            tcc_pkg::UOP_TAB: begin
                priority if (col_reg < ml_reg) begin
                    col_next = ml_reg;
                end else if (tab_stop >= {1'b0, mr_reg}) begin
                    // wrap to the left margin on the next line
                    col_next = ml_reg;
                    if (row_inc > {1'b0, last_row_reg}) begin
                        row_next = last_row_reg;
                        scroll   = 1'b1;
                    end else begin
                        row_next = row_inc[7:0];
                    end
                end else begin
                    col_next = tab_stop[7:0];
                end
            end
            tcc_pkg::UOP_SETL: begin
                if (col_reg < mr_reg) ml_next = col_reg;
                else bell = 1'b1;
            end
            tcc_pkg::UOP_SETR: begin
                if (col_reg > ml_reg) mr_next = col_reg;
                else bell = 1'b1;
            end
            tcc_pkg::UOP_CLRM: begin
                ml_next = 8'd0;
                mr_next = last_col_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= 8'd0;
            col_reg <= 8'd0;
            ml_reg  <= 8'd0;
            mr_reg  <= tcc_pkg::LAST_COL_RST;
        end else if (ctl.en) begin
            row_reg <= row_next;
            col_reg <= col_next;
            ml_reg  <= ml_next;
            mr_reg  <= mr_next;
        end
    end

    assign res = '{bell: bell, scroll: scroll, column: col_next, row: row_next};

endmodule

`default_nettype wire

>>> rtl/tcc_checker.sv
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks for the cursor controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // A stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // One command in flight: an accepted word blocks the next cycle
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while busy");

    // Scroll and bell never come together
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[16] && m_tdata[17]))
        else $error("scroll and bell both set");

    // Reset drops the result stream
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind terminal_cursor_controller tcc_checker u_tcc_checker (.*);

`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the terminal cursor controller. Commands go in
// on the slave stream and are predicted one by one by a behavioral model of
// the cursor, margins and screen size; every result word is checked field
// by field against the oldest prediction. Directed edge cases come first,
// then random traffic over a sweep of screen sizes, a long output stall
// that backs up the input, and a final gap-free stretch.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT     = 2_000_000;
    localparam int         HOLD_CYCLES     = 400;
    localparam int         TAB_STOP        = 8;
    localparam logic [3:0] FIRST_SPARE_CMD = 4'd11;
    localparam logic [3:0] LAST_SPARE_CMD  = 4'd15;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [3:0] cmd, [11:4] count, rest zero
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // [7:0] row, [15:8] column, [16] scroll, [17] bell
    logic        cfg_we;
    logic        cfg_addr;
    logic [8:0]  cfg_wdata;

    terminal_cursor_controller DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Cursor model state
    int unsigned cur_row, cur_col, lmargin, rmargin;
    logic [8:0]  rows_reg, cols_reg;

    // Expected result words, oldest first
    tcc_pkg::res_t cursor_reports_q[$];

    int  fail_count     = 0;
    int  cycle_count    = 0;
    int  words_sent     = 0;
    int  words_checked  = 0;
    int  reg_writes     = 0;
    int  scrolls_seen   = 0;
    int  bells_seen     = 0;
    bit  src_idle_en    = 1'b1;
    bit  snk_idle_en    = 1'b1;
    int  hold_asks      = 0;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // Watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, cycle_count, cursor_reports_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Behavioral cursor model
    // ------------------------------------------------------------------
    function automatic int unsigned eff_size(input logic [8:0] v);
        if (v == 9'd0) return 1;
        if (v > 9'd256) return 256;
        return v;
    endfunction

    function automatic bit row_advance();
        int unsigned last;
        last = eff_size(rows_reg) - 1;
        if (cur_row + 1 > last) begin
            cur_row = last;
            return 1'b1;
        end
        cur_row = cur_row + 1;
        return 1'b0;
    endfunction

    function automatic void row_down_wrap();
        if (cur_row < eff_size(rows_reg) - 1) cur_row++;
        else cur_row = 0;
    endfunction

    function automatic void row_up_wrap();
        if (cur_row > 0) cur_row--;
        else cur_row = eff_size(rows_reg) - 1;
    endfunction

    function automatic tcc_pkg::res_t step_cursor(input logic [3:0] c,
                                                  input logic [7:0] n);
        tcc_pkg::res_t r;
        bit            scr;
        bit            bel;
        int unsigned   stop;
        int unsigned   last_col;
        scr = 1'b0;
        bel = 1'b0;
        last_col = eff_size(cols_reg) - 1;
        case (c)
            tcc_pkg::CMD_LF:     scr = row_advance();
            tcc_pkg::CMD_BS:     if (cur_col > 0) cur_col--;
            tcc_pkg::CMD_CR:     cur_col = lmargin;
            tcc_pkg::CMD_NEXTLN: repeat (n) row_down_wrap();
            tcc_pkg::CMD_PREVLN: repeat (n) row_up_wrap();
            tcc_pkg::CMD_BACKCH: begin
                repeat (n) begin
                    if (cur_col > 0) begin
                        cur_col--;
                    end else begin
                        cur_col = last_col;
                        row_up_wrap();
                    end
                end
            end
            tcc_pkg::CMD_FWDCH: begin
                repeat (n) begin
                    if (cur_col < last_col) begin
                        cur_col++;
                    end else begin
                        cur_col = 0;
                        row_down_wrap();
                    end
                end
            end
            tcc_pkg::CMD_TAB: begin
                if (cur_col < lmargin) begin
                    cur_col = lmargin;
                end else begin
                    stop = (cur_col / TAB_STOP + 1) * TAB_STOP;
                    if (stop >= rmargin) begin
                        cur_col = lmargin;
                        scr = row_advance();
                    end else begin
                        cur_col = stop;
                    end
                end
            end
            tcc_pkg::CMD_SETL: begin
                if (cur_col < rmargin) lmargin = cur_col;
                else bel = 1'b1;
            end
            tcc_pkg::CMD_SETR: begin
                if (cur_col > lmargin) rmargin = cur_col;
                else bel = 1'b1;
            end
            tcc_pkg::CMD_CLRM: begin
                lmargin = 0;
                rmargin = last_col;
            end
            default: ;  // spare codes: report position only
        endcase
        cur_row &= 8'hFF;
        cur_col &= 8'hFF;
        lmargin &= 8'hFF;
        rmargin &= 8'hFF;
        r.row    = cur_row[7:0];
        r.column = cur_col[7:0];
        r.scroll = scr;
        r.bell   = bel;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : check_results
        tcc_pkg::res_t got;
        tcc_pkg::res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = tcc_pkg::res_t'(m_tdata[17:0]);
            if (cursor_reports_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected word, expected none actual row %0d col %0d",
                         $time, got.row, got.column);
            end else begin
                want = cursor_reports_q.pop_front();
                check_field("row", want.row, got.row);
                check_field("column", want.column, got.column);
                check_field("scroll", want.scroll, got.scroll);
                check_field("bell", want.bell, got.bell);
                check_field("pad bits", 0, m_tdata[23:18]);
                words_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result-side ready: random stall bursts plus a requested long hold
    // ------------------------------------------------------------------
    initial begin : sink_ready
        int hold_taken;
        int hold_left;
        int stall_left;
        hold_taken = 0;
        hold_left  = 0;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_asks != hold_taken) begin
                hold_taken = hold_asks;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (snk_idle_en && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks (all start and end on a falling edge)
    // ------------------------------------------------------------------

    // Offer one word; s_tvalid stays high on return for back-to-back words
    task automatic send_command(input logic [3:0] c, input logic [7:0] n);
        tcc_pkg::res_t want;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, n, c};
        do @(posedge aclk); while (!s_tready);
        want = step_cursor(c, n);
        cursor_reports_q.push_back(want);
        words_sent++;
        scrolls_seen += want.scroll;
        bells_seen   += want.bell;
        @(negedge aclk);
    endtask

    task automatic send_random_command();
        logic [3:0] c;
        logic [7:0] n;
        if ($urandom_range(0, 99) < 5)
            c = 4'($urandom_range(FIRST_SPARE_CMD, LAST_SPARE_CMD));
        else
            c = 4'($urandom_range(tcc_pkg::CMD_LF, tcc_pkg::CMD_CLRM));
        // mostly short repeats, now and then the full count range
        if ($urandom_range(0, 6) == 0) n = 8'($urandom);
        else n = 8'($urandom_range(0, 12));
        send_command(c, n);
    endtask

    // Drop valid and wait until every result is back
    task automatic wait_block_idle();
        s_tvalid <= 1'b0;
        while (cursor_reports_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_register(input logic idx, input logic [8:0] val);
        wait_block_idle();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == tcc_pkg::REG_NUM_ROWS) rows_reg = val;
        else cols_reg = val;
        reg_writes++;
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic apply_reset();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = tcc_pkg::REG_NUM_ROWS;
        cfg_wdata = '0;
        cur_row   = 0;
        cur_col   = 0;
        lmargin   = 0;
        rmargin   = tcc_pkg::LAST_COL_RST;
        rows_reg  = 9'd24;
        cols_reg  = 9'd80;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
    endtask

    // Edges of the 24 x 80 reset screen, margins and tab wrap
    task automatic test_home_and_edges();
        send_command(LAST_SPARE_CMD, 8'd255);          // reset position, spare code
        send_command(tcc_pkg::CMD_BS, 8'd0);           // backspace stuck at column 0
        send_command(tcc_pkg::CMD_PREVLN, 8'd1);       // wrap to the bottom row
        send_command(tcc_pkg::CMD_LF, 8'd0);           // line feed at bottom scrolls
        send_command(tcc_pkg::CMD_NEXTLN, 8'd1);       // wrap to the top row
        send_command(tcc_pkg::CMD_BACKCH, 8'd1);       // wrap to last column, last row
        send_command(tcc_pkg::CMD_FWDCH, 8'd1);        // wrap back to home
        send_command(tcc_pkg::CMD_FWDCH, 8'd255);      // full count across rows
        send_command(tcc_pkg::CMD_TAB, 8'd0);
        send_command(tcc_pkg::CMD_SETL, 8'd0);
        send_command(tcc_pkg::CMD_CR, 8'd0);
        send_command(tcc_pkg::CMD_BS, 8'd0);
        send_command(tcc_pkg::CMD_TAB, 8'd0);          // left of margin: jump to it
        send_command(tcc_pkg::CMD_SETR, 8'd0);         // right margin at left one: bell
        send_command(tcc_pkg::CMD_FWDCH, 8'd20);
        send_command(tcc_pkg::CMD_SETR, 8'd0);
        send_command(tcc_pkg::CMD_TAB, 8'd0);          // stop past right margin wraps
        send_command(tcc_pkg::CMD_FWDCH, 8'd30);
        send_command(tcc_pkg::CMD_SETL, 8'd0);         // left margin past right: bell
        send_command(tcc_pkg::CMD_CLRM, 8'd0);
        send_command(tcc_pkg::CMD_PREVLN, 8'd5);
        send_command(tcc_pkg::CMD_FWDCH, 8'd26);
        send_command(tcc_pkg::CMD_TAB, 8'd0);          // tab wrap on bottom row scrolls
        send_command(tcc_pkg::CMD_NEXTLN, 8'd0);       // zero count: no motion
        send_command(FIRST_SPARE_CMD, 8'd0);
    endtask

    // Random traffic over a sweep of screen sizes, extremes included
    task automatic test_screen_sizes();
        logic [8:0] rows_set[8];
        logic [8:0] cols_set[8];
        rows_set = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd2, 9'd24, 9'd0, 9'd0};
        cols_set = '{9'd256, 9'd1, 9'd0, 9'd300, 9'd9, 9'd80, 9'd0, 9'd0};
        for (int p = 0; p < 8; p++) begin
            if (p >= 6) begin
                rows_set[p] = 9'($urandom_range(0, 511));
                cols_set[p] = 9'($urandom_range(0, 511));
            end
            write_register(tcc_pkg::REG_NUM_ROWS, rows_set[p]);
            write_register(tcc_pkg::REG_NUM_COLS, cols_set[p]);
            // usually reset margins to the new width, sometimes keep stale ones
            if ($urandom_range(0, 9) < 7) send_command(tcc_pkg::CMD_CLRM, 8'd0);
            repeat (110) send_random_command();
        end
    endtask

    // Receiver holds off while the sender keeps offering words
    task automatic test_output_backpressure();
        wait_block_idle();
        @(posedge aclk);
        hold_asks++;
        @(negedge aclk);
        repeat (30) send_random_command();
    endtask

    // Closing stretch with no idling on either side
    task automatic test_streaming_no_gaps();
        // stop new sink stalls first so any running burst drains while idle
        snk_idle_en = 1'b0;
        wait_block_idle();
        src_idle_en = 1'b0;
        repeat (300) send_random_command();
    endtask

    task automatic finish_run();
        s_tvalid <= 1'b0;
        while (cursor_reports_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        $display("Covered %0d commands over 8 screen sizes with %0d register writes;",
                 words_sent, reg_writes);
        $display("%0d words checked, %0d scrolls, %0d bells, %0d cycles, %0d failures.",
                 words_checked, scrolls_seen, bells_seen, cycle_count, fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    endtask

    initial begin
        apply_reset();
        test_home_and_edges();
        test_screen_sizes();
        test_output_backpressure();
        test_streaming_no_gaps();
        finish_run();
    end

endmodule
